@@ hw/rtl/ddo_pkg.sv @@
// shared types, constants and helpers for the differential drive odometry block
package ddo_pkg;

    // input opcodes
    typedef enum logic [1:0] {
        OP_SAMPLE    = 2'd0,
        OP_SET_POSE  = 2'd1,
        OP_CLEAR_XY  = 2'd2,
        OP_CLEAR_ALL = 2'd3
    } opcode_t;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_SCALE = 2'd1;
    localparam logic [1:0] CFG_ITW   = 2'd2;

    // configuration reset values
    localparam logic [31:0] SCALE_RESET = 32'd1864171;
    localparam logic [31:0] ITW_RESET   = 32'd62119;

    // shared multiplier operand width and product width
    localparam int MulW  = 34;
    localparam int ProdW = 2 * MulW;

    // division by one million: shift by 6, then multiply by floor(2^45/15625)
    localparam logic [31:0] DIV_RECIP = 32'd2251799813;
    localparam logic [13:0] DIV_ODD   = 14'd15625;
    localparam logic [51:0] DIV_HALF  = 52'd500000;
    localparam int QuoW     = 32;
    localparam int DivSteps = 5;

    // cordic setup
    localparam int CordicSteps = 20;
    localparam logic [32:0] CORDIC_GAIN = 33'h026DD3B6A;
    localparam logic [33:0] TURN32_PER_RAD = 34'd683565276;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // arctangent table, 2^32 units per turn
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // clamp a signed value to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic signed [36:0] hi;
        logic signed [36:0] lo;
        logic [31:0] r;
        hi = 37'sh0_7FFF_FFFF;
        lo = -37'sh0_8000_0000;
        if (v > hi)
            r = 32'h7FFF_FFFF;
        else if (v < lo)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/ddo_mul.sv @@
// shared signed multiplier with registered product
module ddo_mul
    import ddo_pkg::*;
(
    input  logic                    clk,
    input  logic                    go,
    input  logic signed [MulW-1:0]  a,
    input  logic signed [MulW-1:0]  b,
    output logic [ProdW-1:0]        p
);

    logic [ProdW-1:0] p_reg;

    // product holds until the next issue
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/ddo_div.sv @@
// divider by one million through reciprocal multiplication, rounding halves away from zero
module ddo_div
    import ddo_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [51:0]   num_mag,
    input  logic          num_neg,
    output logic [32:0]   quo,
    output unit_status_t  status
);

    logic [45:0]     m_reg;
    logic [54:0]     lo_reg;
    logic [54:0]     hi_reg;
    logic [QuoW-1:0] q_reg;
    logic [45:0]     qm_reg;
    logic            neg_reg;
    logic [2:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [51:0]     biased;
    logic [77:0]     acc;
    logic [45:0]     rem;
    logic [QuoW-1:0] q_fix;

    assign biased = num_mag + DIV_HALF;
    assign acc    = {hi_reg, 23'd0} + {23'd0, lo_reg};
    assign rem    = m_reg - qm_reg;

    // estimate is at most two below the true quotient
    always_comb
    begin
        if (rem >= {31'd0, DIV_ODD, 1'b0})
            q_fix = q_reg + 32'd2;
        else if (rem >= {32'd0, DIV_ODD})
            q_fix = q_reg + 32'd1;
        else
            q_fix = q_reg;
    end

    // control: fixed step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'(DivSteps - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'(DivSteps - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // datapath: split product, estimate, back-multiply, correct
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg   <= biased[51:6];
            neg_reg <= num_neg;
        end
        else if (busy_reg)
        begin
            case (cnt_reg)
                3'd0:    lo_reg <= {32'd0, m_reg[22:0]} * {23'd0, DIV_RECIP};
                3'd1:    hi_reg <= {32'd0, m_reg[45:23]} * {23'd0, DIV_RECIP};
                3'd2:    q_reg  <= acc[76:45];
                3'd3:    qm_reg <= {14'd0, q_reg} * {32'd0, DIV_ODD};
                3'd4:    q_reg  <= q_fix;
                default: ;
            endcase
        end
    end

    assign quo    = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    assign status = '{busy: busy_reg, done: done_reg};

endmodule

@@ hw/rtl/ddo_cordic.sv @@
// iterative rotation cordic giving cosine and sine in Q2.30
module ddo_cordic
    import ddo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         angle,
    output logic signed [32:0]  cs,
    output logic signed [32:0]  sn,
    output unit_status_t        status
);

    logic signed [32:0] x_reg;
    logic signed [32:0] y_reg;
    logic signed [33:0] z_reg;
    logic               flip_reg;
    logic [4:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [33:0] at;
    logic               start_flip;
    logic [31:0]        start_z;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign at = $signed({2'b00, atan_turn32(step_reg)});

    // fold angles in the left half plane by half a turn
    assign start_flip = angle[31] ^ angle[30];
    assign start_z    = {angle[31] ^ start_flip, angle[30:0]};

    // control: one micro-rotation per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 5'(CordicSteps - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(CordicSteps - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // rotation datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed(CORDIC_GAIN);
            y_reg    <= '0;
            z_reg    <= $signed({{2{start_z[31]}}, start_z});
            flip_reg <= start_flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cs     = flip_reg ? -x_reg : x_reg;
    assign sn     = flip_reg ? -y_reg : y_reg;
    assign status = '{busy: busy_reg, done: done_reg};

endmodule

@@ hw/rtl/differential_drive_odometry.sv @@
// Dead-reckoning odometry: a speed sample runs two 5-step reciprocal divisions by one million
// and two 20-step cordic runs, with its other products on a shared mul.
// Pose opcodes skip the arithmetic and go straight to the result stage. One item is in work at a time; the
// next is taken the cycle after its result enters the output register. A result waits for
// out_ready while the output register still holds an unaccepted one.
// Reset (rst_n low, asynchronous) clears the pose and held speeds and loads config defaults.
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   opcode,
    input  logic [15:0]  right_rpm,
    input  logic [15:0]  left_rpm,
    input  logic [19:0]  elapsed_us,
    input  logic [31:0]  new_x,
    input  logic [31:0]  new_y,
    input  logic [15:0]  new_heading,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  pos_x,
    output logic [31:0]  pos_y,
    output logic [15:0]  heading,
    output logic [31:0]  vel_x,
    output logic [31:0]  vel_y,
    output logic [31:0]  yaw_rate,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [18:0] {
        ST_IDLE      = 19'b000_0000_0000_0000_0001,
        ST_MUL_OM    = 19'b000_0000_0000_0000_0010,
        ST_MUL_DIST  = 19'b000_0000_0000_0000_0100,
        ST_DIV_DIST  = 19'b000_0000_0000_0000_1000,
        ST_WAIT_DIST = 19'b000_0000_0000_0001_0000,
        ST_WAIT_RAD  = 19'b000_0000_0000_0010_0000,
        ST_MUL_P     = 19'b000_0000_0000_0100_0000,
        ST_ANGLE     = 19'b000_0000_0000_1000_0000,
        ST_CORDIC1   = 19'b000_0000_0001_0000_0000,
        ST_MUL_DX    = 19'b000_0000_0010_0000_0000,
        ST_MUL_DY    = 19'b000_0000_0100_0000_0000,
        ST_POSY      = 19'b000_0000_1000_0000_0000,
        ST_CORDIC2   = 19'b000_0001_0000_0000_0000,
        ST_MUL_VX    = 19'b000_0010_0000_0000_0000,
        ST_MUL_VY    = 19'b000_0100_0000_0000_0000,
        ST_VY        = 19'b000_1000_0000_0000_0000,
        ST_WR        = 19'b001_0000_0000_0000_0000,
        ST_WL        = 19'b010_0000_0000_0000_0000,
        ST_DONE      = 19'b100_0000_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic        mode_reg;
    logic [31:0] scale_reg;
    logic [31:0] itw_reg;

    // odometry state
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [15:0] hd_reg;
    logic [31:0] hr_reg;
    logic [31:0] hl_reg;

    // per-item working registers
    logic [16:0] rpm_r_reg;
    logic [16:0] rpm_l_reg;
    logic [19:0] el_reg;
    logic [31:0] om_reg;
    logic [32:0] dist_reg;
    logic [32:0] rad_reg;
    logic [32:0] cs_reg;
    logic [32:0] sn_reg;
    logic [31:0] vx_reg;
    logic [31:0] vy_reg;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] res_px_reg;
    logic [31:0] res_py_reg;
    logic [15:0] res_hd_reg;
    logic [31:0] res_vx_reg;
    logic [31:0] res_vy_reg;
    logic [31:0] res_yaw_reg;

    // shared units
    logic                   mul_go;
    logic signed [MulW-1:0] mul_a;
    logic signed [MulW-1:0] mul_b;
    logic [ProdW-1:0]       mul_q;
    logic                   div_start;
    logic [32:0]            div_q;
    unit_status_t           div_st;
    logic                   cor_start;
    logic [31:0]            cor_angle;
    logic signed [32:0]     cor_cs;
    logic signed [32:0]     cor_sn;
    unit_status_t           cor_st;

    logic in_acc;
    logic out_acc;
    logic load_out;

    // mean speed and speed difference from held wheel speeds
    logic [32:0] spd_sum;
    logic [31:0] v_lin;
    logic [32:0] spd_diff;
    logic        diff_neg;
    logic [32:0] diff_abs;

    assign spd_sum  = {hr_reg[31], hr_reg} + {hl_reg[31], hl_reg};
    assign v_lin    = spd_sum[32:1];
    assign spd_diff = {hr_reg[31], hr_reg} - {hl_reg[31], hl_reg};
    assign diff_neg = spd_diff[32];
    assign diff_abs = diff_neg ? -spd_diff : spd_diff;

    // yaw rate from |diff| * itw, rounded, signed and clamped
    logic [48:0] om_mag;
    logic [31:0] om_val;

    assign om_mag = {1'b0, mul_q[63:16]} + {48'd0, mul_q[15]};
    always_comb
    begin
        if (!diff_neg)
            om_val = (om_mag[48:31] != '0) ? 32'h7FFF_FFFF : om_mag[31:0];
        else
            om_val = (om_mag[48:31] != '0) ? 32'h8000_0000 : -om_mag[31:0];
    end

    // signed product magnitude for the divider
    logic [52:0] div_num;
    logic [52:0] div_abs;

    assign div_num = mul_q[52:0];
    assign div_abs = div_num[52] ? -div_num : div_num;

    // turn step and midpoint angle from rad * 2^32/(2*pi)
    logic [63:0] hsum;
    logic [63:0] rsum;
    logic [15:0] hd_step;
    logic [31:0] trig_angle;

    assign hsum       = mul_q[63:0] + (64'd1 << 31);
    assign rsum       = mul_q[63:0] + (64'd1 << 16);
    assign hd_step    = hsum[47:32];
    assign trig_angle = mode_reg ? ({hd_reg, 16'd0} + rsum[48:17]) : {hd_reg, 16'd0};

    // product scaled back from Q2.30 with rounding
    logic [65:0] rnd30;
    logic [35:0] d36;
    logic [36:0] pos_sum;
    logic [31:0] pos_sat;
    logic [31:0] pos_src;

    assign rnd30   = mul_q[65:0] + (66'd1 << 29);
    assign d36     = rnd30[65:30];
    assign pos_src = (state_reg == ST_MUL_DY) ? px_reg : py_reg;
    assign pos_sum = {{5{pos_src[31]}}, pos_src} + {d36[35], d36};
    assign pos_sat = sat32($signed(pos_sum));

    // wheel speed from rpm * scale, rounded and clamped
    logic [50:0] ws_rnd;
    logic [34:0] ws35;
    logic [31:0] ws_sat;

    assign ws_rnd = mul_q[50:0] + (51'd1 << 15);
    assign ws35   = ws_rnd[50:16];
    assign ws_sat = sat32($signed({{2{ws35[34]}}, ws35}));

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid_reg && out_ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // multiplier operand select
    always_comb
    begin
        mul_go = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MUL_OM:
            begin
                mul_a = $signed({2'b00, diff_abs[31:0]});
                mul_b = $signed({2'b00, itw_reg});
            end
            ST_MUL_DIST:
            begin
                mul_a = $signed({{2{v_lin[31]}}, v_lin});
                mul_b = $signed({14'd0, el_reg});
            end
            ST_DIV_DIST:
            begin
                mul_a = $signed({{2{om_reg[31]}}, om_reg});
                mul_b = $signed({14'd0, el_reg});
            end
            ST_MUL_P:
            begin
                mul_a = $signed({rad_reg[32], rad_reg});
                mul_b = $signed(TURN32_PER_RAD);
            end
            ST_MUL_DX:
            begin
                mul_a = $signed({dist_reg[32], dist_reg});
                mul_b = $signed({cs_reg[32], cs_reg});
            end
            ST_MUL_DY:
            begin
                mul_a = $signed({dist_reg[32], dist_reg});
                mul_b = $signed({sn_reg[32], sn_reg});
            end
            ST_MUL_VX:
            begin
                mul_a = $signed({{2{v_lin[31]}}, v_lin});
                mul_b = $signed({cs_reg[32], cs_reg});
            end
            ST_MUL_VY:
            begin
                mul_a = $signed({{2{v_lin[31]}}, v_lin});
                mul_b = $signed({sn_reg[32], sn_reg});
            end
            ST_VY:
            begin
                mul_a = $signed({{17{rpm_r_reg[16]}}, rpm_r_reg});
                mul_b = $signed({2'b00, scale_reg});
            end
            ST_WR:
            begin
                mul_a = $signed({{17{rpm_l_reg[16]}}, rpm_l_reg});
                mul_b = $signed({2'b00, scale_reg});
            end
            default:
            begin
                mul_go = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        cor_start  = 1'b0;
        cor_angle  = trig_angle;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = (opcode_t'(opcode) == OP_SAMPLE) ? ST_MUL_OM : ST_DONE;
            end
            ST_MUL_OM:    state_next = ST_MUL_DIST;
            ST_MUL_DIST:  state_next = ST_DIV_DIST;
            ST_DIV_DIST:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_DIST;
            end
            ST_WAIT_DIST:
            begin
                if (div_st.done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT_RAD;
                end
            end
            ST_WAIT_RAD:
            begin
                if (div_st.done)
                    state_next = ST_MUL_P;
            end
            ST_MUL_P:     state_next = ST_ANGLE;
            ST_ANGLE:
            begin
                cor_start  = 1'b1;
                state_next = ST_CORDIC1;
            end
            ST_CORDIC1:
            begin
                cor_angle = {hd_reg, 16'd0};
                if (cor_st.done)
                begin
                    cor_start  = 1'b1;
                    state_next = ST_MUL_DX;
                end
            end
            ST_MUL_DX:    state_next = ST_MUL_DY;
            ST_MUL_DY:    state_next = ST_POSY;
            ST_POSY:      state_next = ST_CORDIC2;
            ST_CORDIC2:
            begin
                if (cor_st.done)
                    state_next = ST_MUL_VX;
            end
            ST_MUL_VX:    state_next = ST_MUL_VY;
            ST_MUL_VY:    state_next = ST_VY;
            ST_VY:        state_next = ST_WR;
            ST_WR:        state_next = ST_WL;
            ST_WL:        state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // result handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_acc)
            out_valid_next = 1'b0;
    end

    // control, configuration and odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            scale_reg     <= SCALE_RESET;
            itw_reg       <= ITW_RESET;
            px_reg        <= '0;
            py_reg        <= '0;
            hd_reg        <= '0;
            hr_reg        <= '0;
            hl_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:  mode_reg  <= cfg_data[0];
                    CFG_SCALE: scale_reg <= cfg_data;
                    CFG_ITW:   itw_reg   <= cfg_data;
                    default:   ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (opcode_t'(opcode))
                            OP_SET_POSE:
                            begin
                                px_reg <= new_x;
                                py_reg <= new_y;
                                hd_reg <= new_heading;
                            end
                            OP_CLEAR_XY:
                            begin
                                px_reg <= '0;
                                py_reg <= '0;
                            end
                            OP_CLEAR_ALL:
                            begin
                                px_reg <= '0;
                                py_reg <= '0;
                                hd_reg <= '0;
                                hr_reg <= '0;
                                hl_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ANGLE: hd_reg <= hd_reg + hd_step;
                ST_MUL_DY: px_reg <= pos_sat;
                ST_POSY:   py_reg <= pos_sat;
                ST_WR:     hr_reg <= ws_sat;
                ST_WL:     hl_reg <= ws_sat;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                rpm_r_reg <= {right_rpm[15], right_rpm};
                rpm_l_reg <= -{left_rpm[15], left_rpm};
                el_reg    <= elapsed_us;
                om_reg    <= '0;
                vx_reg    <= '0;
                vy_reg    <= '0;
            end
            ST_MUL_DIST: om_reg <= om_val;
            ST_WAIT_DIST:
            begin
                if (div_st.done)
                    dist_reg <= div_q;
            end
            ST_WAIT_RAD:
            begin
                if (div_st.done)
                    rad_reg <= div_q;
            end
            ST_CORDIC1, ST_CORDIC2:
            begin
                if (cor_st.done)
                begin
                    cs_reg <= cor_cs;
                    sn_reg <= cor_sn;
                end
            end
            ST_MUL_VY: vx_reg <= d36[31:0];
            ST_VY:     vy_reg <= d36[31:0];
            default: ;
        endcase
        if (load_out)
        begin
            res_px_reg  <= px_reg;
            res_py_reg  <= py_reg;
            res_hd_reg  <= hd_reg;
            res_vx_reg  <= vx_reg;
            res_vy_reg  <= vy_reg;
            res_yaw_reg <= om_reg;
        end
    end

    ddo_mul u_mul (
        .clk (clk),
        .go  (mul_go),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_q)
    );

    ddo_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (div_abs[51:0]),
        .num_neg (div_num[52]),
        .quo     (div_q),
        .status  (div_st)
    );

    ddo_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .angle  (cor_angle),
        .cs     (cor_cs),
        .sn     (cor_sn),
        .status (cor_st)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pos_x     = res_px_reg;
    assign pos_y     = res_py_reg;
    assign heading   = res_hd_reg;
    assign vel_x     = res_vx_reg;
    assign vel_y     = res_vy_reg;
    assign yaw_rate  = res_yaw_reg;

`ifndef ASSERT_OFF
    // iterative units are quiet whenever the sequencer is idle
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!div_st.busy && !cor_st.busy))
        else $error("iterative unit busy while idle");

    // divider results only land in a state that waits for them
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == ST_WAIT_DIST || state_reg == ST_WAIT_RAD))
        else $error("divider result dropped");

    // cordic results only land in a state that waits for them
    a_cor_done: assert property (@(posedge clk) disable iff (!rst_n)
        cor_st.done |-> (state_reg == ST_CORDIC1 || state_reg == ST_CORDIC2))
        else $error("cordic result dropped");

    // an accepted transaction keeps the block busy for the next cycle
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input taken twice in a row");
`endif

endmodule

@@ tb/differential_drive_odometry_test.sv @@
// testbench for the odometry block: random and directed items checked against a predictor
module differential_drive_odometry_test;
    import ddo_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [15:0] right_rpm;
    logic [15:0] left_rpm;
    logic [19:0] elapsed_us;
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic [15:0] new_heading;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] yaw_rate;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] hd;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] yaw;
    } pose_result_t;

    pose_result_t pending_poses[$];
    int  mismatch_count;
    bit  idle_enable;
    int  stall_left = 0;

    // predictor state and configuration
    bit          mdl_rk2;
    logic [31:0] mdl_scale;
    logic [31:0] mdl_itw;
    longint      mdl_x;
    longint      mdl_y;
    logic [15:0] mdl_hd;
    longint      mdl_right;
    longint      mdl_left;

    differential_drive_odometry uut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint per_million(longint v);
        if (v >= 0)
            return (v + 500000) / 1000000;
        return -((-v + 500000) / 1000000);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // sine and cosine in Q2.30, angle 2^32 per turn
    task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] a;
        longint x, y, z, xs, ys, t;
        bit flip;
        flip = ang[31] ^ ang[30];
        a = flip ? ang + 32'h8000_0000 : ang;
        z = longint'($signed(a));
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < CordicSteps; i++)
        begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            t = longint'(atan_turn32(i[4:0]));
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= t;
            end
            else
            begin
                x += ys; y -= xs; z += t;
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // advance the predicted pose by one item
    task automatic predict_pose(input opcode_t op, input logic [15:0] rr, input logic [15:0] lr,
                                input logic [19:0] el, input logic [31:0] nx,
                                input logic [31:0] ny, input logic [15:0] nh);
        pose_result_t r;
        longint v, diff, om, dist_m, rad, p, cs, sn, vx, vy, rl;
        logic [63:0] mag;
        logic [31:0] tang;
        vx = 0; vy = 0; om = 0;
        case (op)
            OP_SAMPLE:
            begin
                v = floor_sh(mdl_right + mdl_left, 1);
                diff = mdl_right - mdl_left;
                mag = 64'(diff < 0 ? -diff : diff) * {32'd0, mdl_itw};
                om = longint'((mag >> 16) + ((mag >> 15) & 64'd1));
                om = clamp32(diff < 0 ? -om : om);
                dist_m = per_million(v * longint'(el));
                rad = per_million(om * longint'(el));
                p = rad * 64'sd683565276;
                tang = {mdl_hd, 16'd0};
                if (mdl_rk2)
                    tang += 32'(round_sh(p, 17));
                sin_cos(tang, cs, sn);
                mdl_x = clamp32(mdl_x + round_sh(dist_m * cs, 30));
                mdl_y = clamp32(mdl_y + round_sh(dist_m * sn, 30));
                mdl_hd = mdl_hd + 16'(round_sh(p, 32));
                sin_cos({mdl_hd, 16'd0}, cs, sn);
                vx = round_sh(v * cs, 30);
                vy = round_sh(v * sn, 30);
                rl = -longint'($signed(lr));
                mdl_right = clamp32(round_sh(longint'($signed(rr)) * longint'(mdl_scale), 16));
                mdl_left = clamp32(round_sh(rl * longint'(mdl_scale), 16));
            end
            OP_SET_POSE:
            begin
                mdl_x = longint'($signed(nx));
                mdl_y = longint'($signed(ny));
                mdl_hd = nh;
            end
            OP_CLEAR_XY:
            begin
                mdl_x = 0; mdl_y = 0;
            end
            default:
            begin
                mdl_x = 0; mdl_y = 0; mdl_hd = 0; mdl_right = 0; mdl_left = 0;
            end
        endcase
        r.px = 32'(mdl_x); r.py = 32'(mdl_y); r.hd = mdl_hd;
        r.vx = 32'(vx); r.vy = 32'(vy); r.yaw = 32'(om);
        pending_poses.push_back(r);
    endtask

    task automatic random_gap();
        if (idle_enable && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) @(posedge clk);
    endtask

    // send one item and queue its prediction
    task automatic send_item(input opcode_t op, input logic [15:0] rr, input logic [15:0] lr,
                             input logic [19:0] el, input logic [31:0] nx,
                             input logic [31:0] ny, input logic [15:0] nh);
        random_gap();
        in_valid <= 1'b1;
        opcode <= op; right_rpm <= rr; left_rpm <= lr; elapsed_us <= el;
        new_x <= nx; new_y <= ny; new_heading <= nh;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pose(op, rr, lr, el, nx, ny, nh);
        in_valid <= 1'b0;
        // the block is busy in the cycle after a transaction
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MODE)
            mdl_rk2 = val[0];
        else if (idx == CFG_SCALE)
            mdl_scale = val;
        else if (idx == CFG_ITW)
            mdl_itw = val;
        @(posedge clk);
    endtask

    // random item: mostly samples, most with moderate speeds and times, else pose opcodes
    task automatic send_random();
        int k;
        logic [31:0] a, b;
        k = $urandom_range(0, 99);
        a = $urandom; b = $urandom;
        if (k < 80)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(OP_SAMPLE, a[15:0], b[15:0], 20'($urandom), a, b, b[31:16]);
            else
                send_item(OP_SAMPLE, 16'($signed($urandom_range(0, 8000)) - 4000),
                          16'($signed($urandom_range(0, 8000)) - 4000),
                          20'($urandom_range(0, 100000)), a, b, a[31:16]);
        end
        else if (k < 90)
            send_item(OP_SET_POSE, a[15:0], b[15:0], 20'($urandom), a, b, b[31:16]);
        else if (k < 96)
            send_item(OP_CLEAR_XY, a[15:0], b[15:0], 20'($urandom), a, b, b[31:16]);
        else
            send_item(OP_CLEAR_ALL, a[15:0], b[15:0], 20'($urandom), a, b, b[31:16]);
    endtask

    task automatic test_directed();
        send_item(OP_SAMPLE, 16'h7FFF, 16'h8000, 20'hFFFFF, '0, '0, '0);
        send_item(OP_SAMPLE, 16'h8000, 16'h7FFF, 20'd500000, '0, '0, '0);
        send_item(OP_SAMPLE, 16'd1000, 16'hFC18, 20'd0, '0, '0, '0);
        send_item(OP_SAMPLE, 16'd0, 16'd0, 20'hFFFFF, '0, '0, '0);
        send_item(OP_SET_POSE, '0, '0, '0, 32'h7FFF_FF00, 32'h8000_0100, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h7FFF, 16'h8001, 20'hFFFFF, '0, '0, '0);
        send_item(OP_SAMPLE, 16'h7FFF, 16'h8001, 20'hFFFFF, '0, '0, '0);
        send_item(OP_SET_POSE, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h4000);
        send_item(OP_SAMPLE, 16'h8000, 16'h8000, 20'hFFFFF, '0, '0, '0);
        send_item(OP_SAMPLE, 16'h8000, 16'h8000, 20'hFFFFF, '0, '0, '0);
        send_item(OP_CLEAR_XY, 16'hFFFF, 16'hFFFF, 20'hFFFFF, '1, '1, '1);
        send_item(OP_SAMPLE, 16'd10, 16'd10, 20'd20000, '0, '0, '0);
        send_item(OP_CLEAR_ALL, 16'hFFFF, 16'hFFFF, 20'hFFFFF, '1, '1, '1);
        send_item(OP_SAMPLE, 16'd0, 16'd0, 20'd1, '0, '0, '0);
    endtask

    task automatic test_config_sweep();
        write_register(CFG_MODE, 32'd1);
        test_directed();
        wait_drained();
        write_register(CFG_SCALE, 32'hFFFF_FFFF);
        write_register(CFG_ITW, 32'hFFFF_FFFF);
        test_directed();
        wait_drained();
        write_register(CFG_SCALE, 32'd0);
        write_register(CFG_ITW, 32'd0);
        write_register(CFG_MODE, 32'd0);
        test_directed();
        wait_drained();
        write_register(2'd3, 32'hFFFF_FFFF);
        write_register(CFG_SCALE, SCALE_RESET);
        write_register(CFG_ITW, ITW_RESET);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_register(CFG_MODE, 32'(ph & 1));
            if (ph == 2)
                write_register(CFG_SCALE, $urandom_range(1000000, 8000000));
            for (int i = 0; i < 380; i++)
            begin
                if (ph == 3 && i == 300)
                    idle_enable = 1'b0;
                if (i == 100)
                    while (pending_poses.size() != 0)
                        @(posedge clk);
                send_random();
            end
            wait_drained();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        pose_result_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{pos_x, pos_y, heading, vel_x, vel_y, yaw_rate};
            if (pending_poses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction %h", got);
            end
            else
            begin
                want = pending_poses.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp x=%h y=%h h=%h vx=%h vy=%h w=%h got %h %h %h %h %h %h",
                                 want.px, want.py, want.hd, want.vx, want.vy, want.yaw,
                                 got.px, got.py, got.hd, got.vx, got.vy, got.yaw);
                end
            end
        end
    end

    // receiver drops out_ready at random in bursts while idle_enable is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0; cfg_valid = 1'b0;
        opcode = OP_SAMPLE; right_rpm = '0; left_rpm = '0; elapsed_us = '0;
        new_x = '0; new_y = '0; new_heading = '0; cfg_index = CFG_MODE; cfg_data = '0;
        mismatch_count = 0; idle_enable = 1'b1;
        mdl_rk2 = 1'b0; mdl_scale = SCALE_RESET; mdl_itw = ITW_RESET;
        mdl_x = 0; mdl_y = 0; mdl_hd = '0; mdl_right = 0; mdl_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_config_sweep();
        test_random();
        wait_drained();
        if (mismatch_count == 0 && pending_poses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_mul.sv
hw/rtl/ddo_div.sv
hw/rtl/ddo_cordic.sv
hw/rtl/differential_drive_odometry.sv
tb/differential_drive_odometry_test.sv
